// ===== hdl/ptps_pkg.sv =====
package ptps_pkg;

    // Defaults for the top-level parameters.
    localparam int PTPS_POSITIONS  = 16;
    localparam int PTPS_TILT_RATIO = 4;

    // The goal table never holds more slots than a 4-bit index can reach.
    localparam int MAX_SLOTS = 16;

    localparam int ANGLE_W  = 24;
    localparam int TS_W     = 48;
    localparam int IDX_W    = 4;
    localparam int GOAL_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int MARGIN_W = 15;
    localparam int DELAY_W  = 32;

    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Request codes.
    localparam logic [2:0] REQ_PAN   = 3'd0;
    localparam logic [2:0] REQ_TILT  = 3'd1;
    localparam logic [2:0] REQ_LEFT  = 3'd2;
    localparam logic [2:0] REQ_RIGHT = 3'd3;
    localparam logic [2:0] REQ_LOAD  = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_PAN     = 2'd0;
    localparam logic [1:0] KIND_TILT    = 2'd1;
    localparam logic [1:0] KIND_CAPTURE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_POSITION_COUNT = 2'd0;
    localparam logic [1:0] CFG_ERROR_MARGIN   = 2'd1;
    localparam logic [1:0] CFG_FRAME_DELAY    = 2'd2;

    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd1;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 15'd41;
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 32'd0;

    // 2^16 * 2.8125 / pi, maps 2^-12 rad onto 1/64 degree.
    localparam logic [15:0] DEG64_MUL = 16'd58671;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [ANGLE_W-1:0] angle;
        logic [TS_W-1:0]           timestamp_us;
        logic [IDX_W-1:0]          entry_index;
        logic [GOAL_W-1:0]         entry_pan;
        logic [GOAL_W-1:0]         entry_tilt;
        logic signed [ANGLE_W-1:0] tilt_quot;
        logic signed [ANGLE_W-1:0] angle_deg;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                result_kind;
        logic signed [ANGLE_W-1:0] value_a;
        logic signed [ANGLE_W-1:0] value_b;
        logic [IDX_W-1:0]          captured_position;
        logic                      last;
    } res_t;

    // Magnitude of a 24-bit angle minus a 16-bit goal.
    function automatic logic [ANGLE_W:0] abs_diff(input logic signed [ANGLE_W-1:0] a,
                                                  input logic signed [GOAL_W-1:0] b);
        logic signed [ANGLE_W:0] d;
        d = {a[ANGLE_W-1], a} - {{(ANGLE_W-GOAL_W+1){b[GOAL_W-1]}}, b};
        return d[ANGLE_W] ? (ANGLE_W+1)'(-d) : d;
    endfunction

    // 2^-12 rad to 1/64 degree, magnitude rounded half up, sign kept.
    function automatic logic signed [ANGLE_W-1:0] to_deg64(input logic signed [ANGLE_W-1:0] x);
        logic [ANGLE_W-1:0] mag;
        logic [39:0]        prod;
        logic [ANGLE_W-1:0] r;
        mag  = x[ANGLE_W-1] ? ANGLE_W'(-x) : x;
        prod = 40'(mag) * 40'(DEG64_MUL) + 40'd32768;
        r    = prod[39:16];
        return x[ANGLE_W-1] ? ANGLE_W'(-r) : r;
    endfunction

    // Following table slot, wrapping at the effective count.
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
                                                   input logic [COUNT_W-1:0] eff);
        logic [COUNT_W-1:0] inc;
        inc = {1'b0, idx} + 5'd1;
        return (inc >= eff) ? '0 : inc[IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/ptps_ram.sv =====
module ptps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write-first: a read of the address being written returns the new word.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
        rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
    end

endmodule

// ===== hdl/pan_tilt_panorama_sequencer.sv =====
// Pan-tilt panorama sequencer.
//
// Input beats (s_ channel) carry pan and tilt samples, left and right frame
// events and goal-table loads; the request code travels on s_tuser. Result
// beats (m_ channel) carry pan commands, tilt commands and capture records;
// the result kind travels on m_tuser and m_tlast marks the final result of
// an input beat. Registers are written on the cfg_ channel, which is always
// ready, and should only be written while no input beat is outstanding.
//
// An accepted beat is registered in the input register, is evaluated in a
// single pass against the goal RAM, and its results are registered in the
// output buffer. One beat per cycle is sustained while the receiver keeps
// m_tready high. A capture produces three result beats, and the input
// register then holds the next beat until the last two drain. If m_tready
// is low, results wait in the three-entry output buffer and the input
// register fills, after which s_tready drops.
//
// Reset clears the sequencing state, the stored tilt and the registers to
// their defaults; goal table entries are undefined until loaded.
module pan_tilt_panorama_sequencer #(
    parameter int POSITIONS  = ptps_pkg::PTPS_POSITIONS,
    parameter int TILT_RATIO = ptps_pkg::PTPS_TILT_RATIO
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata, from bit 0: angle[24], timestamp_us[48], entry_index[4],
    // entry_pan[16], entry_tilt[16], then four zero bits.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptps_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[3].
    input  logic [ptps_pkg::S_TUSER_W-1:0]  s_tuser,
    // m_tdata, from bit 0: value_a[24], value_b[24], captured_position[4],
    // then four zero bits.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptps_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: result_kind[2].
    output logic [ptps_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ptps_pkg::*;

    // Slots actually stored, and the address width of the goal RAM.
    localparam int TDEPTH = (POSITIONS < MAX_SLOTS) ? POSITIONS : MAX_SLOTS;
    localparam int AW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam logic [COUNT_W-1:0] TDEPTH_C = COUNT_W'(TDEPTH);

    // Rounded-up reciprocal of the gear ratio over 2^31; exact for every
    // magnitude of a 24-bit angle.
    localparam logic [32:0] RECIP_FULL =
        ((33'd1 << 31) + 33'(TILT_RATIO) - 33'd1) / 33'(TILT_RATIO);
    localparam logic [31:0] TILT_RECIP = RECIP_FULL[31:0];
    localparam logic [ANGLE_W-1:0] RATIO_C = ANGLE_W'(TILT_RATIO);

    // Configuration registers.
    logic [COUNT_W-1:0]  count_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [DELAY_W-1:0]  delay_reg;

    // Input register.
    logic     in_valid_reg, in_valid_next;
    in_item_t in_reg;
    in_item_t in_item;
    logic     s_accept;

    // Sequencing state.
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      armed_reg, armed_next;
    logic                      left_reg, left_next;
    logic                      right_reg, right_next;
    logic [TS_W-1:0]           arrival_reg, arrival_next;
    logic signed [ANGLE_W-1:0] tilt_now_reg, tilt_now_next;

    // Output buffer, head at entry 0.
    res_t       res_reg [3];
    res_t       new_res [3];
    logic [1:0] res_cnt_reg;
    logic [1:0] new_cnt;
    logic       m_take;
    logic       buf_free;
    logic       proc_fire;
    logic       cap_fire;

    // Goal RAM: {tilt, pan} per slot. Port A reads the current slot, port B
    // the slot that follows it.
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [2*GOAL_W-1:0]       ram_wdata;
    logic [AW-1:0]             ram_raddr_a, ram_raddr_b;
    logic [2*GOAL_W-1:0]       ram_rdata_a, ram_rdata_b;
    logic signed [GOAL_W-1:0]  cur_pan, cur_tilt, nxt_pan, nxt_tilt;

    logic [COUNT_W-1:0]        eff_count;
    logic [IDX_W-1:0]          succ_idx, succ_succ_idx;
    logic [ANGLE_W:0]          margin_w;
    logic                      pan_in_margin;
    logic                      tilt_out;
    logic                      frame_late;
    logic signed [ANGLE_W-1:0] tilt_cmd;
    logic signed [ANGLE_W-1:0] tilt_deg;

    // Intake: the raw tilt is divided by the gear ratio and the pan angle is
    // turned into degrees on the way into the input register.
    logic [ANGLE_W-1:0]        in_mag;
    logic [55:0]               quot_prod;
    logic [ANGLE_W-1:0]        quot_mag;

    always_comb begin
        in_item.req_type     = s_tuser[2:0];
        in_item.angle        = s_tdata[23:0];
        in_item.timestamp_us = s_tdata[71:24];
        in_item.entry_index  = s_tdata[75:72];
        in_item.entry_pan    = s_tdata[91:76];
        in_item.entry_tilt   = s_tdata[107:92];
        in_mag    = in_item.angle[ANGLE_W-1] ? ANGLE_W'(-in_item.angle) : in_item.angle;
        quot_prod = 56'(in_mag) * 56'(TILT_RECIP);
        quot_mag  = quot_prod[54:31];
        in_item.tilt_quot = in_item.angle[ANGLE_W-1] ? ANGLE_W'(-quot_mag) : quot_mag;
        in_item.angle_deg = to_deg64(in_item.angle);
    end

    // Handshakes. An item is evaluated once the output buffer is empty or
    // hands over its last waiting beat in this cycle.
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (res_cnt_reg != 2'd0);
    assign m_take    = m_tvalid && m_tready;
    assign buf_free  = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && m_tready);
    assign proc_fire = in_valid_reg && buf_free;
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tdata = {4'd0, res_reg[0].captured_position, res_reg[0].value_b,
                      res_reg[0].value_a};
    assign m_tuser = res_reg[0].result_kind;
    assign m_tlast = res_reg[0].last;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= COUNT_RESET;
            margin_reg <= MARGIN_RESET;
            delay_reg  <= DELAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_POSITION_COUNT: count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_ERROR_MARGIN:   margin_reg <= cfg_data[MARGIN_W-1:0];
                CFG_FRAME_DELAY:    delay_reg  <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // A count of zero behaves as one; a count above the table size is capped.
    always_comb begin
        if (count_reg == '0) begin
            eff_count = 5'd1;
        end else if (count_reg > TDEPTH_C) begin
            eff_count = TDEPTH_C;
        end else begin
            eff_count = count_reg;
        end
    end

    assign succ_idx      = next_slot(idx_reg, eff_count);
    assign succ_succ_idx = next_slot(succ_idx, eff_count);

    // The RAM is addressed with the slot that will be current in the next
    // cycle, so its registered data always matches idx_reg.
    assign ram_raddr_a = idx_next[AW-1:0];
    assign ram_raddr_b = cap_fire ? succ_succ_idx[AW-1:0] : succ_idx[AW-1:0];

    assign cur_pan  = ram_rdata_a[GOAL_W-1:0];
    assign cur_tilt = ram_rdata_a[2*GOAL_W-1:GOAL_W];
    assign nxt_pan  = ram_rdata_b[GOAL_W-1:0];
    assign nxt_tilt = ram_rdata_b[2*GOAL_W-1:GOAL_W];

    assign margin_w      = (ANGLE_W+1)'(margin_reg);
    assign pan_in_margin = (abs_diff(in_reg.angle, cur_pan) <= margin_w) &&
                           (abs_diff(tilt_now_reg, cur_tilt) <= margin_w);
    assign tilt_out      = abs_diff(in_reg.tilt_quot, cur_tilt) > margin_w;
    // The deadline is formed one bit wider so that it never wraps.
    assign frame_late    = {1'b0, in_reg.timestamp_us} >
                           ({1'b0, arrival_reg} + (TS_W+1)'(delay_reg));
    assign tilt_cmd      = {{(ANGLE_W-GOAL_W){cur_tilt[GOAL_W-1]}}, cur_tilt} * RATIO_C;
    assign tilt_deg      = to_deg64(tilt_now_reg);

    assign ram_waddr = in_reg.entry_index[AW-1:0];
    assign ram_wdata = {in_reg.entry_tilt, in_reg.entry_pan};

    // Evaluation of the item in the input register.
    always_comb begin
        idx_next      = idx_reg;
        armed_next    = armed_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        arrival_next  = arrival_reg;
        tilt_now_next = tilt_now_reg;
        new_res[0]    = '0;
        new_res[1]    = '0;
        new_res[2]    = '0;
        new_cnt       = 2'd0;
        cap_fire      = 1'b0;
        ram_we        = 1'b0;
        if (proc_fire) begin
            unique case (in_reg.req_type)
                REQ_PAN: begin
                    if (!pan_in_margin) begin
                        new_res[0].result_kind = KIND_PAN;
                        new_res[0].value_a     = ANGLE_W'(cur_pan);
                        new_res[0].last        = 1'b1;
                        new_cnt                = 2'd1;
                    end else if (!armed_reg) begin
                        armed_next   = 1'b1;
                        arrival_next = in_reg.timestamp_us;
                    end else if (left_reg && right_reg) begin
                        // Capture: record, then the goal of the following slot.
                        cap_fire   = 1'b1;
                        armed_next = 1'b0;
                        left_next  = 1'b0;
                        right_next = 1'b0;
                        idx_next   = succ_idx;
                        new_res[0].result_kind       = KIND_CAPTURE;
                        new_res[0].value_a           = in_reg.angle_deg;
                        new_res[0].value_b           = tilt_deg;
                        new_res[0].captured_position = idx_reg;
                        new_res[1].result_kind       = KIND_PAN;
                        new_res[1].value_a           = ANGLE_W'(nxt_pan);
                        new_res[2].result_kind       = KIND_TILT;
                        new_res[2].value_a           = ANGLE_W'(nxt_tilt);
                        new_res[2].last              = 1'b1;
                        new_cnt                      = 2'd3;
                    end
                end
                REQ_TILT: begin
                    tilt_now_next = in_reg.tilt_quot;
                    if (tilt_out) begin
                        new_res[0].result_kind = KIND_TILT;
                        new_res[0].value_a     = tilt_cmd;
                        new_res[0].last        = 1'b1;
                        new_cnt                = 2'd1;
                    end
                end
                REQ_LEFT: begin
                    if (armed_reg && frame_late) begin
                        left_next = 1'b1;
                    end
                end
                REQ_RIGHT: begin
                    if (armed_reg && frame_late) begin
                        right_next = 1'b1;
                    end
                end
                REQ_LOAD: begin
                    ram_we = (32'(in_reg.entry_index) < POSITIONS);
                end
                default: ;
            endcase
        end
    end

    assign in_valid_next = s_accept ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            idx_reg      <= '0;
            armed_reg    <= 1'b0;
            left_reg     <= 1'b0;
            right_reg    <= 1'b0;
            arrival_reg  <= '0;
            tilt_now_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            idx_reg      <= idx_next;
            armed_reg    <= armed_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            arrival_reg  <= arrival_next;
            tilt_now_reg <= tilt_now_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= in_item;
        end
    end

    // Output buffer occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 2'd0;
        end else if (proc_fire) begin
            res_cnt_reg <= new_cnt;
        end else if (m_take) begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    // Output buffer payload: refilled on evaluation, shifted on each beat.
    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            res_reg[0] <= new_res[0];
            res_reg[1] <= new_res[1];
            res_reg[2] <= new_res[2];
        end else if (m_take) begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    ptps_ram #(
        .WIDTH (2*GOAL_W),
        .DEPTH (TDEPTH)
    ) u_goal_ram (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_addr_a (ram_raddr_a),
        .rd_data_a (ram_rdata_a),
        .rd_addr_b (ram_raddr_b),
        .rd_data_b (ram_rdata_b)
    );

`ifndef NO_ASSERTIONS
    // A capture record is always followed by the pan command of the new slot.
    a_capture_then_pan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_take && m_tuser == KIND_CAPTURE) |=>
        (m_tvalid && m_tuser == KIND_PAN && !m_tlast))
        else $error("capture record not followed by pan command");

    // The final beat of an item is the last one left in the buffer.
    a_last_is_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (res_cnt_reg == 2'd1))
        else $error("last beat with further results queued");

    // The slot index moves only on a capture.
    a_index_on_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && idx_reg != $past(idx_reg)) |-> $past(cap_fire))
        else $error("slot index changed without a capture");

    // An item that cannot be evaluated stays put in the input register.
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !buf_free) |=> (in_valid_reg && $stable(in_reg)))
        else $error("waiting input item lost or changed");
`endif

endmodule
